[hw/rtl/parallel_port_interface_adapter_assert.svh]
// ---------------------------------------------------------------------------
// parallel port interface adapter assertion macros
// shared property shapes for the adapter checks, clocked on clk, off in reset
// ---------------------------------------------------------------------------
`ifndef PARALLEL_PORT_INTERFACE_ADAPTER_ASSERT_SVH
`define PARALLEL_PORT_INTERFACE_ADAPTER_ASSERT_SVH

// same-cycle implication
`define PIA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("adapter check failed: same-cycle rule");

// next-cycle implication
`define PIA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("adapter check failed: next-cycle rule");

`endif

[hw/rtl/pia_pkg.sv]
// ---------------------------------------------------------------------------
// pia_pkg
// shared types and codes for the parallel port interface adapter
// ---------------------------------------------------------------------------
package pia_pkg;

  // request kinds carried on tuser
  typedef enum logic [2:0] {
    CMD_READ  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_CA1   = 3'd2,
    CMD_CA2   = 3'd3,
    CMD_CB1   = 3'd4,
    CMD_CB2   = 3'd5
  } cmd_t;

  // line-2 modes, control bits 5..3
  localparam logic [2:0] MODE_HANDSHAKE = 3'd4;
  localparam logic [2:0] MODE_PULSE     = 3'd5;
  localparam logic [2:0] MODE_LOW       = 3'd6;
  localparam logic [2:0] MODE_HIGH      = 3'd7;

  // control register bit positions
  localparam int CTRL_L1_RISE_BIT  = 1;
  localparam int CTRL_DATA_SEL_BIT = 2;
  localparam int MODE_IRQ_EN_BIT   = 0;  // within the mode field
  localparam int MODE_RISE_BIT     = 1;  // within the mode field
  localparam int MODE_OUTPUT_BIT   = 2;  // within the mode field

  // one port's share of a request
  typedef struct packed {
    logic       rd;
    logic       wr;
    logic       ctrl_sel;
    logic       l1_ev;
    logic       l2_ev;
    logic       level;
    logic [7:0] wdata;
    logic [7:0] pins;
  } port_req_t;

  // one port's status after a request
  typedef struct packed {
    logic       irq;
    logic [7:0] drive;
    logic       l2;
  } port_stat_t;

endpackage

[hw/rtl/pia_port.sv]
// ---------------------------------------------------------------------------
// pia_port
// one adapter port: output, direction and control registers, line state
// and interrupt flags, updated once per request
// ---------------------------------------------------------------------------
module pia_port (
  input  logic               clk,
  input  logic               rst,
  input  pia_pkg::port_req_t req,
  output logic [7:0]         rd_data,
  output pia_pkg::port_stat_t stat_next
);
  import pia_pkg::*;

  logic [7:0] out_reg, out_reg_next;
  logic [7:0] dir_reg, dir_reg_next;
  logic [5:0] ctrl,    ctrl_next;
  logic       l1_last, l1_last_next;
  logic       l2,      l2_next;
  logic       flag1,   flag1_next;
  logic       flag2,   flag2_next;

  logic [2:0] mode;
  logic [2:0] mode_w;
  logic       l1_hit;
  logic       l2_hit;

  assign mode   = ctrl[5:3];
  // a control write drives line 2 from the newly written mode
  assign mode_w = req.ctrl_sel ? req.wdata[5:3] : mode;

  // edge detection on the two lines
  assign l1_hit = ctrl[CTRL_L1_RISE_BIT] ? (!l1_last && req.level)
                                         : (l1_last && !req.level);
  assign l2_hit = mode[MODE_RISE_BIT] ? (!l2 && req.level) : (l2 && !req.level);

  // next state and read data
  always_comb begin
    out_reg_next = out_reg;
    dir_reg_next = dir_reg;
    ctrl_next    = ctrl;
    l1_last_next = l1_last;
    l2_next      = l2;
    flag1_next   = flag1;
    flag2_next   = flag2;
    rd_data      = '0;

    if (req.rd) begin
      if (req.ctrl_sel) begin
        rd_data = {flag1, flag2, ctrl};
      end else if (!ctrl[CTRL_DATA_SEL_BIT]) begin
        rd_data = dir_reg;
      end else begin
        rd_data    = (out_reg & dir_reg) | (req.pins & ~dir_reg);
        flag1_next = 1'b0;
        flag2_next = 1'b0;
        if (mode == MODE_HANDSHAKE) l2_next = 1'b0;
      end
    end

    if (req.wr) begin
      if (req.ctrl_sel || ctrl[CTRL_DATA_SEL_BIT]) begin
        if (req.ctrl_sel) begin
          ctrl_next = req.wdata[5:0];
        end else begin
          out_reg_next = req.wdata;
          flag1_next   = 1'b0;
          flag2_next   = 1'b0;
        end
        if (mode_w == MODE_PULSE || mode_w == MODE_LOW) begin
          l2_next = 1'b0;
        end else if (mode_w == MODE_HIGH) begin
          l2_next = 1'b1;
        end
      end else begin
        dir_reg_next = req.wdata;
      end
    end

    if (req.l1_ev) begin
      l1_last_next = req.level;
      if (l1_hit) begin
        flag1_next = 1'b1;
        if (mode == MODE_HANDSHAKE) l2_next = 1'b1;
      end
    end

    // line 2 events count only in the input modes
    if (req.l2_ev && !mode[MODE_OUTPUT_BIT]) begin
      l2_next = req.level;
      if (mode[MODE_IRQ_EN_BIT] && l2_hit) flag2_next = 1'b1;
    end
  end

  // status as it stands after this request
  assign stat_next.irq   = flag1_next | flag2_next;
  assign stat_next.drive = out_reg_next & dir_reg_next;
  assign stat_next.l2    = l2_next;

  // port state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_reg <= '0;
      dir_reg <= '0;
      ctrl    <= '0;
      l1_last <= 1'b0;
      l2      <= 1'b0;
      flag1   <= 1'b0;
      flag2   <= 1'b0;
    end else begin
      out_reg <= out_reg_next;
      dir_reg <= dir_reg_next;
      ctrl    <= ctrl_next;
      l1_last <= l1_last_next;
      l2      <= l2_next;
      flag1   <= flag1_next;
      flag2   <= flag2_next;
    end
  end

endmodule

[hw/rtl/parallel_port_interface_adapter.sv]
// ---------------------------------------------------------------------------
// parallel_port_interface_adapter
// Two-port parallel interface adapter driven by a request stream. Each
// request (a bus read, a bus write or a level change on CA1, CA2, CB1 or
// CB2) is taken into an input register, applied to both port units in one
// pass of logic and answered by exactly one result carrying the read byte,
// both interrupt lines, both port drives and the CA2/CB2 levels after the
// request. One request is taken every cycle while the result side does not
// stall; a result is offered once its request has passed the input register
// and then the result register. Either register holds its contents while the
// side after it stalls.
// ---------------------------------------------------------------------------
module parallel_port_interface_adapter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // reg_select[1:0], write_data[9:2], port_a_pins[17:10],
  // port_b_pins[25:18], line_level[26], zero fill
  input  logic [31:0] s_axis_tdata,
  // cmd[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[7:0], irq_a[8], irq_b[9], port_a_drive[17:10],
  // port_b_drive[25:18], ca2_out[26], cb2_out[27], zero fill
  output logic [31:0] m_axis_tdata
);
  import pia_pkg::*;

  logic       in_valid;
  cmd_t       in_cmd;
  logic [1:0] in_rs;
  logic [7:0] in_wd;
  logic [7:0] in_pa;
  logic [7:0] in_pb;
  logic       in_lvl;

  logic        out_valid;
  logic [31:0] out_data;
  logic        advance;

  port_req_t  req_a, req_b;
  port_stat_t stat_a, stat_b;
  logic [7:0] rd_a, rd_b;
  logic [7:0] rd_sel;

  // flow control between the two registers
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd <= cmd_t'(s_axis_tuser);
      in_rs  <= s_axis_tdata[1:0];
      in_wd  <= s_axis_tdata[9:2];
      in_pa  <= s_axis_tdata[17:10];
      in_pb  <= s_axis_tdata[25:18];
      in_lvl <= s_axis_tdata[26];
    end
  end

  // request decode for each port
  always_comb begin
    req_a.rd       = advance && (in_cmd == CMD_READ) && !in_rs[1];
    req_a.wr       = advance && (in_cmd == CMD_WRITE) && !in_rs[1];
    req_a.ctrl_sel = in_rs[0];
    req_a.l1_ev    = advance && (in_cmd == CMD_CA1);
    req_a.l2_ev    = advance && (in_cmd == CMD_CA2);
    req_a.level    = in_lvl;
    req_a.wdata    = in_wd;
    req_a.pins     = in_pa;

    req_b.rd       = advance && (in_cmd == CMD_READ) && in_rs[1];
    req_b.wr       = advance && (in_cmd == CMD_WRITE) && in_rs[1];
    req_b.ctrl_sel = in_rs[0];
    req_b.l1_ev    = advance && (in_cmd == CMD_CB1);
    req_b.l2_ev    = advance && (in_cmd == CMD_CB2);
    req_b.level    = in_lvl;
    req_b.wdata    = in_wd;
    req_b.pins     = in_pb;
  end

  pia_port u_port_a (
    .clk       (clk),
    .rst       (rst),
    .req       (req_a),
    .rd_data   (rd_a),
    .stat_next (stat_a)
  );

  pia_port u_port_b (
    .clk       (clk),
    .rst       (rst),
    .req       (req_b),
    .rd_data   (rd_b),
    .stat_next (stat_b)
  );

  // read byte only for a bus read
  always_comb begin
    case (in_cmd)
      CMD_READ: rd_sel = in_rs[1] ? rd_b : rd_a;
      default:  rd_sel = '0;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {4'b0000, stat_b.l2, stat_a.l2, stat_b.drive, stat_a.drive,
                   stat_b.irq, stat_a.irq, rd_sel};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // checks
  `include "parallel_port_interface_adapter_assert.svh"

  `PIA_ASSERT_NEXT(a_result_follows, advance, m_axis_tvalid)
  `PIA_ASSERT_NEXT(a_input_kept, in_valid && !advance, in_valid)
  `PIA_ASSERT_NEXT(a_read_only_byte, advance && (in_cmd != CMD_READ), m_axis_tdata[7:0] == 8'd0)
  `PIA_ASSERT_IMPL(a_one_port_access, advance, !((req_a.rd || req_a.wr) && (req_b.rd || req_b.wr)))

endmodule
